@@ hdl/lcdw_pkg.sv @@
// Shared types and constants for the LCD nibble bus writer.
`timescale 1ns / 1ps
package lcdw_pkg;

    typedef logic [1:0]  t_mode;
    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_nibble;
    typedef logic [15:0] t_ticks;
    typedef logic [1:0]  t_cfg_idx;

    localparam t_mode MODE_TICK  = 2'd0;
    localparam t_mode MODE_INSTR = 2'd1;
    localparam t_mode MODE_DATA  = 2'd2;

    localparam t_cfg_idx CFG_SHORT_WAIT = 2'd0;
    localparam t_cfg_idx CFG_LONG_WAIT  = 2'd1;

    localparam t_ticks SHORT_WAIT_RST = 16'd40;
    localparam t_ticks LONG_WAIT_RST  = 16'd2000;

    localparam t_byte   CMD_CLEAR   = 8'h01;
    localparam t_byte   CMD_HOME    = 8'h02;
    localparam t_nibble FUNC_SET_HI = 4'h2;

endpackage

@@ hdl/lcdw_if.sv @@
// Handshake channels of the LCD nibble bus writer: input word, result word, register write.
`timescale 1ns / 1ps
interface lcdw_in_if;
    logic               valid;
    logic               ready;
    lcdw_pkg::t_mode    mode;
    lcdw_pkg::t_byte    value_byte;

    modport source (output valid, output mode, output value_byte, input ready);
    modport sink   (input valid, input mode, input value_byte, output ready);
endinterface

interface lcdw_out_if;
    logic               valid;
    logic               ready;
    logic               select_line;
    logic               enable_line;
    lcdw_pkg::t_nibble  bus_nibble;
    logic               busy_res;
    logic               rejected;

    modport source (output valid, output select_line, output enable_line,
                    output bus_nibble, output busy_res, output rejected, input ready);
    modport sink   (input valid, input select_line, input enable_line,
                    input bus_nibble, input busy_res, input rejected, output ready);
endinterface

interface lcdw_cfg_if;
    logic               valid;
    logic               ready;
    lcdw_pkg::t_cfg_idx idx;
    lcdw_pkg::t_ticks   data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ hdl/lcd_nibble_interface_writer.sv @@
// Top level: 4-bit character LCD bus writer, one input word per timing tick.
// Results land in the output register, or in the skid entry while the output stalls.
// Throughput: one input word per cycle; a two-entry output stage keeps accepting
//   while one result waits, and ready drops only when both entries are full.
// Register writes are always accepted.
// Reset: synchronous active low; bus state idles, wait registers return to 40 and 2000.
`timescale 1ns / 1ps
module lcd_nibble_interface_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdw_in_if.sink     i_in,
    lcdw_out_if.source  o_out,
    lcdw_cfg_if.sink    i_cfg
);
    import lcdw_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    typedef struct packed {
        logic    select_line;
        logic    enable_line;
        t_nibble bus_nibble;
        logic    busy_res;
        logic    rejected;
    } t_res;

    t_ticks     r_short_wait, r_long_wait;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_nib_left, n_nib_left;
    t_ticks     r_wait_cnt, n_wait_cnt;
    t_byte      r_held_byte, n_held_byte;
    logic       r_held_sel, n_held_sel;
    logic       r_enable, n_enable;
    t_nibble    r_bus, n_bus;
    logic       r_long_flag, n_long_flag;

    t_res       n_res, r_out, r_skid;
    logic       r_out_valid, r_skid_valid;

    logic       in_acc, out_take, wants, rejected, load;
    t_ticks     wait_sel, wc_dec;
    logic [1:0] nl_dec;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign in_acc      = i_in.valid && !r_skid_valid;
    assign out_take    = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_wait <= SHORT_WAIT_RST;
            r_long_wait  <= LONG_WAIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                CFG_SHORT_WAIT: r_short_wait <= i_cfg.data;
                CFG_LONG_WAIT:  r_long_wait  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_nib_left  = r_nib_left;
        n_wait_cnt  = r_wait_cnt;
        n_held_byte = r_held_byte;
        n_held_sel  = r_held_sel;
        n_enable    = r_enable;
        n_bus       = r_bus;
        n_long_flag = r_long_flag;
        wants       = (i_in.mode == MODE_INSTR) || (i_in.mode == MODE_DATA);
        rejected    = 1'b0;
        load        = 1'b0;
        wc_dec      = r_wait_cnt - {15'd0, (r_wait_cnt != '0)};
        nl_dec      = r_nib_left - {1'b0, (r_nib_left != '0)};

        case (r_phase)
            PH_LOW: begin
                rejected   = wants;
                n_wait_cnt = wc_dec;
                if (wc_dec == '0) begin
                    n_enable   = 1'b1;
                    n_nib_left = nl_dec;
                    n_phase    = (nl_dec == '0) ? PH_IDLE : PH_GAP;
                end
            end
            PH_GAP: begin
                rejected = wants;
                // repeated high nibble of a function set takes the short wait
                if (r_nib_left == 2'd2 && r_held_byte[7:4] == FUNC_SET_HI && !r_held_sel)
                    n_long_flag = 1'b0;
                load = 1'b1;
            end
            default: begin
                n_phase  = PH_IDLE;
                n_enable = 1'b1;
                if (wants) begin
                    n_held_byte = i_in.value_byte;
                    n_held_sel  = (i_in.mode == MODE_DATA);
                    if (i_in.mode == MODE_INSTR) begin
                        n_long_flag = (i_in.value_byte == CMD_CLEAR) ||
                                      (i_in.value_byte == CMD_HOME);
                        n_nib_left  = (i_in.value_byte[7:4] == FUNC_SET_HI) ? 2'd3 : 2'd2;
                    end else begin
                        n_long_flag = 1'b0;
                        n_nib_left  = 2'd2;
                    end
                    load = 1'b1;
                end
            end
        endcase

        wait_sel = n_long_flag ? r_long_wait : r_short_wait;
        if (load) begin
            n_bus      = (n_nib_left == 2'd1) ? n_held_byte[3:0] : n_held_byte[7:4];
            n_enable   = 1'b0;
            n_wait_cnt = (wait_sel == '0) ? 16'd1 : wait_sel;
            n_phase    = PH_LOW;
        end

        n_res.select_line = n_held_sel;
        n_res.enable_line = n_enable;
        n_res.bus_nibble  = n_bus;
        n_res.busy_res    = (n_phase != PH_IDLE);
        n_res.rejected    = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_nib_left  <= '0;
            r_wait_cnt  <= '0;
            r_held_byte <= '0;
            r_held_sel  <= 1'b0;
            r_enable    <= 1'b1;
            r_bus       <= '0;
            r_long_flag <= 1'b0;
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_nib_left  <= n_nib_left;
            r_wait_cnt  <= n_wait_cnt;
            r_held_byte <= n_held_byte;
            r_held_sel  <= n_held_sel;
            r_enable    <= n_enable;
            r_bus       <= n_bus;
            r_long_flag <= n_long_flag;
        end
    end

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid)
                r_out <= r_skid;
            else if (in_acc)
                r_out <= n_res;
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.select_line = r_out.select_line;
    assign o_out.enable_line = r_out.enable_line;
    assign o_out.bus_nibble  = r_out.bus_nibble;
    assign o_out.busy_res    = r_out.busy_res;
    assign o_out.rejected    = r_out.rejected;

endmodule

@@ hdl/lcdw_checker.sv @@
// Port-level checks for the LCD nibble bus writer, bound to the top level.
`timescale 1ns / 1ps
module lcdw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_select_line,
    input logic                i_enable_line,
    input lcdw_pkg::t_nibble   i_bus_nibble,
    input logic                i_busy_res,
    input logic                i_rejected
);
    import lcdw_pkg::*;

    // enable only sits low inside a transfer
    a_low_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_enable_line |-> i_busy_res)
        else $error("enable low while not busy");

    // an idle bus always shows enable high
    a_idle_enable_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_busy_res |-> i_enable_line)
        else $error("enable low while idle");

    // input is only refused when results are backed up
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input refused with empty output stage");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_select_line) &&
        $stable(i_enable_line) && $stable(i_bus_nibble) && $stable(i_busy_res) &&
        $stable(i_rejected))
        else $error("stalled result word changed");

endmodule

bind lcd_nibble_interface_writer lcdw_checker u_lcdw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_select_line (o_out.select_line),
    .i_enable_line (o_out.enable_line),
    .i_bus_nibble  (o_out.bus_nibble),
    .i_busy_res    (o_out.busy_res),
    .i_rejected    (o_out.rejected)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the 4-bit LCD bus writer: pin prediction, random pacing, register sweeps.
`timescale 1ns / 1ps
module testbench;
    import lcdw_pkg::*;

    localparam t_mode    MODE_UNUSED     = 2'd3;
    localparam t_cfg_idx CFG_UNUSED_2    = 2'd2;
    localparam t_cfg_idx CFG_UNUSED_3    = 2'd3;
    localparam int       HOLD_OFF_CYCLES = 200;
    localparam int       QUIET_LIMIT     = 2000;

    typedef enum logic [1:0] {LCD_IDLE, LCD_LOW, LCD_GAP} t_lcd_phase;

    typedef struct packed {
        logic    select_line;
        logic    enable_line;
        t_nibble bus_nibble;
        logic    busy_res;
        logic    rejected;
    } t_pins;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    lcdw_in_if  in_ch ();
    lcdw_out_if out_ch ();
    lcdw_cfg_if cfg_ch ();

    lcd_nibble_interface_writer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted bus state
    t_ticks     short_ticks = SHORT_WAIT_RST;
    t_ticks     long_ticks  = LONG_WAIT_RST;
    t_lcd_phase lcd_phase   = LCD_IDLE;
    logic [1:0] nib_left    = 2'd0;
    t_ticks     low_left    = '0;
    t_byte      cur_byte    = '0;
    logic       cur_sel     = 1'b0;
    logic       en_lvl      = 1'b1;
    t_nibble    bus_lvl     = '0;
    logic       use_long    = 1'b0;

    t_pins pins_due[$];
    t_pins pins_exp;
    int    n_err       = 0;
    int    quiet       = 0;
    int    stall_left  = 0;
    bit    steady      = 1'b0;
    bit    hold_off_req = 1'b0;

    function automatic void drive_nibble();
        bus_lvl   = (nib_left == 2'd1) ? cur_byte[3:0] : cur_byte[7:4];
        en_lvl    = 1'b0;
        low_left  = use_long ? long_ticks : short_ticks;
        if (low_left == 16'd0) begin
            low_left = 16'd1;
        end
        lcd_phase = LCD_LOW;
    endfunction

    function automatic t_pins advance_lcd(t_mode m, t_byte b);
        logic  wr;
        logic  rej;
        t_pins p;
        wr  = (m == MODE_INSTR) || (m == MODE_DATA);
        rej = 1'b0;
        case (lcd_phase)
            LCD_LOW: begin
                rej = wr;
                if (low_left != 16'd0) begin
                    low_left = low_left - 16'd1;
                end
                if (low_left == 16'd0) begin
                    en_lvl = 1'b1;
                    if (nib_left != 2'd0) begin
                        nib_left = nib_left - 2'd1;
                    end
                    lcd_phase = (nib_left == 2'd0) ? LCD_IDLE : LCD_GAP;
                end
            end
            LCD_GAP: begin
                rej = wr;
                // repeated function-set high nibble takes the short wait
                if (nib_left == 2'd2 && cur_byte[7:4] == FUNC_SET_HI && !cur_sel) begin
                    use_long = 1'b0;
                end
                drive_nibble();
            end
            default: begin
                lcd_phase = LCD_IDLE;
                en_lvl    = 1'b1;
                if (wr) begin
                    cur_byte = b;
                    cur_sel  = (m == MODE_DATA);
                    if (m == MODE_INSTR) begin
                        use_long = (b == CMD_CLEAR) || (b == CMD_HOME);
                        nib_left = (b[7:4] == FUNC_SET_HI) ? 2'd3 : 2'd2;
                    end else begin
                        use_long = 1'b0;
                        nib_left = 2'd2;
                    end
                    drive_nibble();
                end
            end
        endcase
        p.select_line = cur_sel;
        p.enable_line = en_lvl;
        p.bus_nibble  = bus_lvl;
        p.busy_res    = (lcd_phase != LCD_IDLE);
        p.rejected    = rej;
        return p;
    endfunction

    task automatic send_word(t_mode m, t_byte b);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            gap = 0;
        end else if (r < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.value_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pins_due.push_back(advance_lcd(m, b));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pins_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_ticks data);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_SHORT_WAIT: short_ticks = data;
            CFG_LONG_WAIT:  long_ticks  = data;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    // filler words while a byte goes out; any write among them gets dropped
    task automatic tick_until_idle();
        while (lcd_phase != LCD_IDLE) begin
            send_word(t_mode'($urandom_range(0, 3)), t_byte'($urandom));
        end
    endtask

    task automatic test_reset_waits();
        send_word(MODE_DATA, 8'hA5);
        tick_until_idle();
    endtask

    task automatic test_directed_bytes();
        t_mode m[14];
        t_byte b[14];
        m = '{MODE_INSTR, MODE_INSTR, MODE_INSTR, MODE_INSTR, MODE_INSTR, MODE_INSTR,
              MODE_INSTR, MODE_INSTR, MODE_DATA, MODE_DATA, MODE_DATA, MODE_DATA,
              MODE_UNUSED, MODE_TICK};
        b = '{8'h00, 8'hFF, CMD_CLEAR, CMD_HOME, 8'h20, 8'h2F, 8'h03, 8'h10,
              8'h00, 8'hFF, 8'h01, 8'h2A, 8'hFF, 8'hFF};
        write_reg(CFG_SHORT_WAIT, 16'd1);
        write_reg(CFG_LONG_WAIT, 16'd3);
        foreach (m[i]) begin
            send_word(m[i], b[i]);
            tick_until_idle();
        end
        // back-to-back writes, including one on the final enable rise
        steady = 1'b1;
        repeat (12) send_word($urandom_range(0, 1) ? MODE_INSTR : MODE_DATA, t_byte'($urandom));
        steady = 1'b0;
        tick_until_idle();
    endtask

    task automatic test_zero_and_unused_regs();
        write_reg(CFG_SHORT_WAIT, 16'd0);
        write_reg(CFG_LONG_WAIT, 16'd0);
        write_reg(CFG_UNUSED_2, 16'hFFFF);
        write_reg(CFG_UNUSED_3, t_ticks'($urandom));
        send_word(MODE_INSTR, 8'h28);
        tick_until_idle();
        send_word(MODE_INSTR, CMD_CLEAR);
        tick_until_idle();
        send_word(MODE_DATA, 8'h5A);
        tick_until_idle();
    endtask

    task automatic test_wait_extremes();
        steady = 1'b1;
        write_reg(CFG_SHORT_WAIT, 16'd64);
        write_reg(CFG_LONG_WAIT, 16'd1);
        send_word(MODE_DATA, 8'hC3);
        tick_until_idle();
        send_word(MODE_INSTR, CMD_HOME);
        tick_until_idle();
        write_reg(CFG_SHORT_WAIT, 16'd1);
        write_reg(CFG_LONG_WAIT, 16'd48);
        send_word(MODE_INSTR, CMD_CLEAR);
        tick_until_idle();
        steady = 1'b0;
    endtask

    task automatic test_output_hold_off();
        write_reg(CFG_SHORT_WAIT, 16'd2);
        write_reg(CFG_LONG_WAIT, 16'd5);
        steady       = 1'b1;
        hold_off_req = 1'b1;
        repeat (60) send_word(t_mode'($urandom_range(0, 3)), t_byte'($urandom));
        steady = 1'b0;
        tick_until_idle();
    endtask

    task automatic test_random_traffic();
        int    r;
        t_mode m;
        t_byte b;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_SHORT_WAIT, t_ticks'($urandom_range(1, 6)));
            write_reg(CFG_LONG_WAIT, t_ticks'($urandom_range(1, 15)));
            steady = (ph == 2);
            repeat (200) begin
                r = $urandom_range(0, 99);
                b = t_byte'($urandom);
                if (r < 35) begin
                    m = MODE_TICK;
                end else if (r < 65) begin
                    m = MODE_INSTR;
                    case ($urandom_range(0, 3))
                        0: b = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
                        1: b = {FUNC_SET_HI, t_nibble'($urandom)};
                        default: ;
                    endcase
                end else if (r < 90) begin
                    m = MODE_DATA;
                end else begin
                    m = MODE_UNUSED;
                end
                send_word(m, b);
            end
        end
        steady = 1'b0;
    endtask

    // receiver pacing
    always @(posedge i_clk) begin : rx_pace
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (!steady && r < 20) begin
            stall_left   = (r < 17) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pins_due.size() == 0) begin
                $error("result word with none expected");
                n_err++;
            end else begin
                pins_exp = pins_due.pop_front();
                if (out_ch.select_line !== pins_exp.select_line) begin
                    $error("select_line: expected %0d, actual %0d",
                           pins_exp.select_line, out_ch.select_line);
                    n_err++;
                end
                if (out_ch.enable_line !== pins_exp.enable_line) begin
                    $error("enable_line: expected %0d, actual %0d",
                           pins_exp.enable_line, out_ch.enable_line);
                    n_err++;
                end
                if (out_ch.bus_nibble !== pins_exp.bus_nibble) begin
                    $error("bus_nibble: expected %0h, actual %0h",
                           pins_exp.bus_nibble, out_ch.bus_nibble);
                    n_err++;
                end
                if (out_ch.busy_res !== pins_exp.busy_res) begin
                    $error("busy_res: expected %0d, actual %0d",
                           pins_exp.busy_res, out_ch.busy_res);
                    n_err++;
                end
                if (out_ch.rejected !== pins_exp.rejected) begin
                    $error("rejected: expected %0d, actual %0d",
                           pins_exp.rejected, out_ch.rejected);
                    n_err++;
                end
            end
        end
    end

    // watchdog on handshake silence
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_TICK;
        in_ch.value_byte = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.idx       = CFG_SHORT_WAIT;
        cfg_ch.data      = '0;
        out_ch.ready     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_waits();
        test_directed_bytes();
        test_zero_and_unused_regs();
        test_wait_extremes();
        test_output_hold_off();
        test_random_traffic();

        settle();
        repeat (20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
